// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MGP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgp check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MGP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mgp check failed: next-cycle implication");

`endif

// ===== rtl/mgp_pkg.sv =====
`default_nettype none

package mgp_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;
    localparam int ENTRY_W    = 48;

    // input kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_CHUNK  = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // record kinds
    localparam logic [1:0] REC_SAMPLE    = 2'd0;
    localparam logic [1:0] REC_GOP       = 2'd1;
    localparam logic [1:0] REC_PARTITION = 2'd2;
    localparam logic [1:0] REC_ERROR     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TOTAL_SIZE      = 2'd0;
    localparam logic [1:0] CFG_PARTITION_COUNT = 2'd1;
    localparam logic [1:0] CFG_AVERAGE_SIZE    = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHUNK,
        OP_SAMPLE
    } op_t;

    typedef enum logic [3:0] {
        PH_HEAD,
        PH_SPLIT,
        PH_SAMPLE,
        PH_FGOP,
        PH_FSPLIT,
        PH_FINAL,
        PH_CCMP,
        PH_CSPC
    } phase_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
        logic [15:0] spc;
        logic        sync;
        logic        fin;
    } item_t;

    typedef struct packed {
        logic [31:0] total_size;
        logic [15:0] partition_count;
        logic [31:0] average_size;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/mgp_ram.sv =====
`default_nettype none

module mgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mgp_front.sv =====
`default_nettype none

module mgp_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [mgp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic [1:0]                         s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    output mgp_pkg::item_t                          item,
    output logic                                    item_valid,
    input  wire logic                               item_pop
);

    mgp_pkg::item_t              in_item;
    mgp_pkg::item_t              q_mem [mgp_pkg::QUEUE_DEPTH];
    logic [mgp_pkg::Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mgp_pkg::Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mgp_pkg::QC_W-1:0]    count_reg, count_next;
    logic                        push;

    // classify the incoming transfer
    always_comb
    begin
        in_item.spc  = s_axis_tdata[47:32];
        in_item.sync = s_axis_tdata[104];
        in_item.fin  = s_axis_tlast;
        unique case (s_axis_tuser)
            mgp_pkg::KIND_LOAD:
            begin
                in_item.op   = mgp_pkg::OP_LOAD;
                in_item.word = s_axis_tdata[31:0];
            end
            mgp_pkg::KIND_CHUNK:
            begin
                in_item.op   = mgp_pkg::OP_CHUNK;
                in_item.word = s_axis_tdata[79:48];
            end
            mgp_pkg::KIND_SAMPLE:
            begin
                in_item.op   = mgp_pkg::OP_SAMPLE;
                in_item.word = 32'(s_axis_tdata[103:80]);
            end
            default:
            begin
                in_item.op   = mgp_pkg::OP_NONE;
                in_item.word = s_axis_tdata[31:0];
            end
        endcase
    end

    assign s_axis_tready = (count_reg != mgp_pkg::QC_W'(mgp_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && (in_item.op != mgp_pkg::OP_NONE);
    assign item_valid    = (count_reg != '0);
    assign item          = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + mgp_pkg::Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = item_pop ? rd_ptr_reg + mgp_pkg::Q_AW'(1) : rd_ptr_reg;
        case ({push, item_pop})
            2'b10:   count_next = count_reg + mgp_pkg::QC_W'(1);
            2'b01:   count_next = count_reg - mgp_pkg::QC_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mgp_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module mgp_back #(
    parameter int TABLE_ENTRIES = mgp_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mgp_pkg::cfg_t  cfg,
    input  wire mgp_pkg::item_t item,
    input  wire logic           item_valid,
    output logic                item_pop,
    output logic                rec_valid,
    input  wire logic           rec_ready,
    output logic [1:0]          rec_kind,
    output logic [31:0]         rec_position,
    output logic [31:0]         rec_length,
    output logic                rec_last
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W  = CNT_W + 1;

    mgp_pkg::phase_t     phase_reg, phase_next;

    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [ADDR_W-1:0]   cursor_reg, cursor_next;
    logic [31:0]         chunk_number_reg, chunk_number_next;
    logic [15:0]         samples_left_reg, samples_left_next;
    logic [31:0]         running_offset_reg, running_offset_next;
    logic [31:0]         gop_start_reg, gop_start_next;
    logic                gop_open_reg, gop_open_next;
    logic [31:0]         split_start_reg, split_start_next;
    logic [31:0]         carry_reg, carry_next;
    logic [15:0]         splits_made_reg, splits_made_next;
    logic [31:0]         sample_end_reg, sample_end_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [31:0]         out_pos_reg, out_pos_next;
    logic [31:0]         out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [mgp_pkg::ENTRY_W-1:0] ram_rdata;

    logic                go;
    logic                sl_zero, gop_close_now, table_empty;
    logic                more0, more1, taken;
    logic                room, split_ok;
    logic [31:0]         need, diff, excess;
    logic                do_gop, do_split, do_place, do_final;
    logic [31:0]         place_end;
    logic                in_scan, stream_clear;

    mgp_ram #(
        .WIDTH (mgp_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_count_reg[ADDR_W-1:0]),
        .wdata ({item.spc, item.word}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign go            = item_valid && (!out_valid_reg || rec_ready);
    assign sl_zero       = (samples_left_reg == '0);
    assign gop_close_now = item.sync && gop_open_reg && !item.fin;
    assign table_empty   = (entry_count_reg == '0);
    assign more0 = (CMP_W'(cursor_reg) + CMP_W'(1)) < CMP_W'(entry_count_reg);
    assign more1 = (CMP_W'(cursor_reg) + CMP_W'(2)) < CMP_W'(entry_count_reg);
    assign taken = (ram_rdata[31:0] <= chunk_number_reg);

    // balanced split decision at a gop close
    assign need     = cfg.average_size - carry_reg;
    assign diff     = sample_end_reg - split_start_reg;
    assign excess   = diff - need;
    assign room     = (17'(splits_made_reg) + 17'd1) < 17'(cfg.partition_count);
    assign split_ok = room && (diff >= need);
    assign place_end = running_offset_reg + item.word;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (go)
        begin
            unique case (phase_reg)
                mgp_pkg::PH_HEAD:
                begin
                    case (item.op)
                        mgp_pkg::OP_CHUNK:
                        begin
                            if (table_empty)
                                phase_next = mgp_pkg::PH_HEAD;
                            else
                                phase_next = more0 ? mgp_pkg::PH_CCMP : mgp_pkg::PH_CSPC;
                        end
                        mgp_pkg::OP_SAMPLE:
                        begin
                            if (!sl_zero && gop_close_now)
                                phase_next = mgp_pkg::PH_SPLIT;
                            else
                                phase_next = item.fin ? mgp_pkg::PH_FGOP : mgp_pkg::PH_HEAD;
                        end
                        default: phase_next = mgp_pkg::PH_HEAD;
                    endcase
                end
                mgp_pkg::PH_CCMP:
                    phase_next = (taken && more1) ? mgp_pkg::PH_CCMP : mgp_pkg::PH_CSPC;
                mgp_pkg::PH_CSPC:   phase_next = mgp_pkg::PH_HEAD;
                mgp_pkg::PH_SPLIT:
                    phase_next = split_ok ? mgp_pkg::PH_SAMPLE : mgp_pkg::PH_HEAD;
                mgp_pkg::PH_SAMPLE: phase_next = mgp_pkg::PH_HEAD;
                mgp_pkg::PH_FGOP:
                    phase_next = gop_open_reg ? mgp_pkg::PH_FSPLIT : mgp_pkg::PH_HEAD;
                mgp_pkg::PH_FSPLIT:
                    phase_next = split_ok ? mgp_pkg::PH_FINAL : mgp_pkg::PH_HEAD;
                mgp_pkg::PH_FINAL:  phase_next = mgp_pkg::PH_HEAD;
                default:            phase_next = mgp_pkg::PH_HEAD;
            endcase
        end
    end

    assign item_pop = go && (phase_next == mgp_pkg::PH_HEAD);

    // datapath and record outputs
    always_comb
    begin
        entry_count_next    = entry_count_reg;
        cursor_next         = cursor_reg;
        chunk_number_next   = chunk_number_reg;
        samples_left_next   = samples_left_reg;
        running_offset_next = running_offset_reg;
        gop_start_next      = gop_start_reg;
        gop_open_next       = gop_open_reg;
        split_start_next    = split_start_reg;
        carry_next          = carry_reg;
        splits_made_next    = splits_made_reg;
        sample_end_next     = sample_end_reg;

        out_valid_next = out_valid_reg && !rec_ready;
        out_kind_next  = out_kind_reg;
        out_pos_next   = out_pos_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = cursor_reg;

        do_gop   = 1'b0;
        do_split = 1'b0;
        do_place = 1'b0;
        do_final = 1'b0;

        if (go)
        begin
            unique case (phase_reg)
                mgp_pkg::PH_HEAD:
                begin
                    case (item.op)
                        mgp_pkg::OP_LOAD:
                        begin
                            if (entry_count_reg < CNT_W'(TABLE_ENTRIES))
                            begin
                                ram_we           = 1'b1;
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end
                        mgp_pkg::OP_CHUNK:
                        begin
                            chunk_number_next   = chunk_number_reg + 32'd1;
                            running_offset_next = item.word;
                            if (table_empty)
                            begin
                                samples_left_next = '0;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = more0 ? cursor_reg + ADDR_W'(1) : cursor_reg;
                            end
                        end
                        mgp_pkg::OP_SAMPLE:
                        begin
                            if (sl_zero)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = mgp_pkg::REC_ERROR;
                                out_pos_next   = '0;
                                out_len_next   = item.word;
                                out_last_next  = !item.fin;
                            end
                            else if (gop_close_now)
                                do_gop = 1'b1;
                            else
                                do_place = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                mgp_pkg::PH_CCMP:
                begin
                    ram_re = 1'b1;
                    if (taken)
                    begin
                        cursor_next = cursor_reg + ADDR_W'(1);
                        ram_raddr   = more1 ? cursor_reg + ADDR_W'(2) : cursor_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        ram_raddr = cursor_reg;
                    end
                end
                mgp_pkg::PH_CSPC:   samples_left_next = ram_rdata[47:32];
                mgp_pkg::PH_SPLIT:
                begin
                    if (split_ok)
                        do_split = 1'b1;
                    else
                        do_place = 1'b1;
                end
                mgp_pkg::PH_SAMPLE: do_place = 1'b1;
                mgp_pkg::PH_FGOP:
                begin
                    if (gop_open_reg)
                        do_gop = 1'b1;
                    else
                        do_final = 1'b1;
                end
                mgp_pkg::PH_FSPLIT:
                begin
                    if (split_ok)
                        do_split = 1'b1;
                    else
                        do_final = 1'b1;
                end
                mgp_pkg::PH_FINAL:  do_final = 1'b1;
                default:
                begin
                end
            endcase
        end

        if (do_gop)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = mgp_pkg::REC_GOP;
            out_pos_next   = gop_start_reg;
            out_len_next   = sample_end_reg - gop_start_reg;
            out_last_next  = 1'b0;
            gop_start_next = sample_end_reg;
        end

        if (do_split)
        begin
            carry_next       = (excess > cfg.average_size) ? cfg.average_size : excess;
            out_valid_next   = 1'b1;
            out_kind_next    = mgp_pkg::REC_PARTITION;
            out_pos_next     = split_start_reg;
            out_len_next     = diff;
            out_last_next    = 1'b0;
            split_start_next = sample_end_reg;
            splits_made_next = splits_made_reg + 16'd1;
        end

        if (do_place)
        begin
            running_offset_next = place_end;
            sample_end_next     = place_end;
            samples_left_next   = samples_left_reg - 16'd1;
            if (item.sync)
                gop_open_next = 1'b1;
            if (item.sync || gop_open_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = mgp_pkg::REC_SAMPLE;
                out_pos_next   = running_offset_reg - gop_start_reg;
                out_len_next   = item.word;
                out_last_next  = !item.fin;
            end
        end

        if (do_final)
        begin
            out_valid_next      = 1'b1;
            out_kind_next       = mgp_pkg::REC_PARTITION;
            out_pos_next        = split_start_reg;
            out_len_next        = cfg.total_size - split_start_reg;
            out_last_next       = 1'b1;
            cursor_next         = '0;
            chunk_number_next   = '0;
            samples_left_next   = '0;
            running_offset_next = '0;
            gop_start_next      = '0;
            gop_open_next       = 1'b0;
            split_start_next    = '0;
            carry_next          = '0;
            splits_made_next    = '0;
            sample_end_next     = '0;
        end
    end

    assign rec_valid    = out_valid_reg;
    assign rec_kind     = out_kind_reg;
    assign rec_position = out_pos_reg;
    assign rec_length   = out_len_reg;
    assign rec_last     = out_last_reg;

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_pos_reg  <= out_pos_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= mgp_pkg::PH_HEAD;
            entry_count_reg    <= '0;
            cursor_reg         <= '0;
            chunk_number_reg   <= '0;
            samples_left_reg   <= '0;
            running_offset_reg <= '0;
            gop_start_reg      <= '0;
            gop_open_reg       <= 1'b0;
            split_start_reg    <= '0;
            carry_reg          <= '0;
            splits_made_reg    <= '0;
            sample_end_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            entry_count_reg    <= entry_count_next;
            cursor_reg         <= cursor_next;
            chunk_number_reg   <= chunk_number_next;
            samples_left_reg   <= samples_left_next;
            running_offset_reg <= running_offset_next;
            gop_start_reg      <= gop_start_next;
            gop_open_reg       <= gop_open_next;
            split_start_reg    <= split_start_next;
            carry_reg          <= carry_next;
            splits_made_reg    <= splits_made_next;
            sample_end_reg     <= sample_end_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    assign in_scan      = (phase_reg == mgp_pkg::PH_CCMP) || (phase_reg == mgp_pkg::PH_CSPC);
    assign stream_clear = (splits_made_reg == '0) && !gop_open_reg && (cursor_reg == '0);

    // an item in progress stays at the queue head
    `MGP_ASSERT_IMP(a_busy_holds_item, phase_reg != mgp_pkg::PH_HEAD, item_valid)
    // the entry scan only runs over a loaded table
    `MGP_ASSERT_IMP(a_scan_nonempty, in_scan, !table_empty)
    // closing the file returns the stream state to its start
    `MGP_ASSERT_NXT(a_close_resets, do_final, stream_clear)

endmodule

`default_nettype wire

// ===== rtl/mp4_gop_partitioner.sv =====
`default_nettype none

// Resolves an mp4 sample table into gop-relative sample records, gop records and
// balanced partition records. A sample that closes a gop yields the gop record, any
// partition record and then its own sample record; a closing sample is placed first,
// then closes the open gop and the file. Records leave through a single output
// register, and processing holds while a record waits there. A chunk start on an empty
// table sets no samples; otherwise it steps through the later table entries, comparing
// each first chunk, through the registered read port of the entry table. Items of an
// unknown kind are dropped on input. A four-entry queue sits between input and
// processing, so input transfers keep flowing while a record waits on the output until
// the queue fills. The entry table needs no clearing after reset. Configuration writes
// are taken at any time but must only be made while the block is idle.
module mp4_gop_partitioner #(
    parameter int TABLE_ENTRIES = mgp_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // first_chunk_number, samples_per_chunk, chunk_offset, sample_size, is_sync, zero pad
    input  wire logic [mgp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind
    input  wire logic [1:0]                       s_axis_tuser,
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // position, length
    output logic [mgp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // record_kind
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    mgp_pkg::cfg_t   cfg_reg, cfg_next;
    mgp_pkg::item_t  item;
    logic            item_valid;
    logic            item_pop;
    logic [31:0]     rec_position;
    logic [31:0]     rec_length;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mgp_pkg::CFG_TOTAL_SIZE:      cfg_next.total_size      = cfg_data;
                mgp_pkg::CFG_PARTITION_COUNT: cfg_next.partition_count = cfg_data[15:0];
                mgp_pkg::CFG_AVERAGE_SIZE:    cfg_next.average_size    = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_size      <= 32'd1;
            cfg_reg.partition_count <= 16'd1;
            cfg_reg.average_size    <= 32'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mgp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    mgp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .rec_valid    (m_axis_tvalid),
        .rec_ready    (m_axis_tready),
        .rec_kind     (m_axis_tuser),
        .rec_position (rec_position),
        .rec_length   (rec_length),
        .rec_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {rec_length, rec_position};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] position;
        logic [31:0] length;
        logic        last;
    } record_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] first_chunk;
        logic [15:0] per_chunk;
        logic [31:0] offset;
        logic [23:0] size;
        logic        sync;
        logic        fin;
    } media_item_t;

    class gop_partition_checker;
        logic [31:0] first_tbl [mgp_pkg::TABLE_ENTRIES_DEFAULT];
        logic [15:0] spc_tbl [mgp_pkg::TABLE_ENTRIES_DEFAULT];
        int          entries;
        int          cursor;
        logic [31:0] chunk_no;
        logic [15:0] left_in_chunk;
        logic [31:0] run_off;
        logic [31:0] gop_start;
        logic        gop_open;
        logic [31:0] split_start;
        logic [31:0] carry;
        logic [15:0] splits;
        logic [31:0] sample_end;
        logic [31:0] total_size;
        logic [15:0] part_count;
        logic [31:0] avg_size;
        record_t     pending_records [$];
        int          mismatches;

        function new();
            entries = 0;
            total_size = 32'd1;
            part_count = 16'd1;
            avg_size = 32'd1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            cursor = 0;
            chunk_no = '0;
            left_in_chunk = '0;
            run_off = '0;
            gop_start = '0;
            gop_open = 1'b0;
            split_start = '0;
            carry = '0;
            splits = '0;
            sample_end = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                mgp_pkg::CFG_TOTAL_SIZE:      total_size = value;
                mgp_pkg::CFG_PARTITION_COUNT: part_count = value[15:0];
                mgp_pkg::CFG_AVERAGE_SIZE:    avg_size = value;
                default: ;
            endcase
        endfunction

        function void push(logic [1:0] kind, logic [31:0] pos, logic [31:0] len);
            record_t r;
            r.kind = kind;
            r.position = pos;
            r.length = len;
            r.last = 1'b0;
            pending_records.insert(pending_records.size(), r);
        endfunction

        function void close_gop(logic [31:0] end_off);
            logic [31:0] need;
            logic [31:0] span;
            push(mgp_pkg::REC_GOP, gop_start, end_off - gop_start);
            gop_start = end_off;
            if ({1'b0, splits} + 17'd1 >= {1'b0, part_count})
                return;
            need = avg_size - carry;
            span = end_off - split_start;
            if (span >= need)
            begin
                carry = (span - need > avg_size) ? avg_size : span - need;
                push(mgp_pkg::REC_PARTITION, split_start, span);
                split_start = end_off;
                splits = splits + 16'd1;
            end
        endfunction

        function void close_file();
            if (gop_open)
                close_gop(sample_end);
            push(mgp_pkg::REC_PARTITION, split_start, total_size - split_start);
            restart();
        endfunction

        function void take_media_item(logic [1:0] kind, logic [mgp_pkg::IN_DATA_W-1:0] data,
                                      logic fin);
            int          before_count;
            logic [31:0] off;
            logic [31:0] sz;
            logic        sync;
            before_count = pending_records.size();
            case (kind)
                mgp_pkg::KIND_LOAD:
                begin
                    if (entries < mgp_pkg::TABLE_ENTRIES_DEFAULT)
                    begin
                        first_tbl[entries] = data[31:0];
                        spc_tbl[entries] = data[47:32];
                        entries++;
                    end
                end
                mgp_pkg::KIND_CHUNK:
                begin
                    chunk_no = chunk_no + 32'd1;
                    run_off = data[79:48];
                    if (entries == 0)
                        left_in_chunk = '0;
                    else
                    begin
                        if (cursor >= entries)
                            cursor = entries - 1;
                        while (cursor + 1 < entries && first_tbl[cursor + 1] <= chunk_no)
                            cursor++;
                        left_in_chunk = spc_tbl[cursor];
                    end
                end
                mgp_pkg::KIND_SAMPLE:
                begin
                    sz = {8'd0, data[103:80]};
                    sync = data[104];
                    if (left_in_chunk == 0)
                        push(mgp_pkg::REC_ERROR, 32'd0, sz);
                    else
                    begin
                        off = run_off;
                        if (sync)
                        begin
                            if (gop_open && !fin)
                                close_gop(sample_end);
                            gop_open = 1'b1;
                        end
                        run_off = off + sz;
                        sample_end = run_off;
                        left_in_chunk = left_in_chunk - 16'd1;
                        if (gop_open)
                            push(mgp_pkg::REC_SAMPLE, off - gop_start, sz);
                    end
                    if (fin)
                        close_file();
                end
                default: ;
            endcase
            if (pending_records.size() > before_count)
                pending_records[pending_records.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            if (mismatches < 50)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_record(logic [1:0] kind, logic [31:0] pos, logic [31:0] len, logic last);
            record_t want;
            if (pending_records.size() == 0)
            begin
                report($sformatf("record with nothing expected: kind %0d position %0h length %0h",
                                 kind, pos, len));
                return;
            end
            want = pending_records.pop_front();
            if (kind !== want.kind)
                report($sformatf("record kind %0d, expected %0d", kind, want.kind));
            if (pos !== want.position)
                report($sformatf("position %0h, expected %0h", pos, want.position));
            if (len !== want.length)
                report($sformatf("length %0h, expected %0h", len, want.length));
            if (last !== want.last)
                report($sformatf("last flag %0b, expected %0b", last, want.last));
        endtask

        function int outstanding();
            return pending_records.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [mgp_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           s_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mgp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index;
    logic [31:0]                    cfg_data;

    gop_partition_checker gop_check = new();
    int          src_idle;
    int          dst_idle;
    int          items_sent;
    int unsigned cycle_count = 0;

    mp4_gop_partitioner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle);

    // input transfers feed the predictor, output transfers are checked in order
    always @(posedge clk)
        if (rst_n && s_axis_tvalid && s_axis_tready)
            gop_check.take_media_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            gop_check.check_record(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                   m_axis_tlast);

    function automatic media_item_t random_item();
        media_item_t it;
        it.kind = 2'($urandom_range(3));
        it.first_chunk = $urandom;
        it.per_chunk = 16'($urandom);
        it.offset = $urandom;
        it.size = 24'($urandom);
        it.sync = 1'($urandom);
        it.fin = 1'($urandom);
        return it;
    endfunction

    function automatic media_item_t load_item(logic [31:0] first_chunk, logic [15:0] per_chunk);
        media_item_t it;
        it = random_item();
        it.kind = mgp_pkg::KIND_LOAD;
        it.first_chunk = first_chunk;
        it.per_chunk = per_chunk;
        return it;
    endfunction

    function automatic media_item_t chunk_item(logic [31:0] offset);
        media_item_t it;
        it = random_item();
        it.kind = mgp_pkg::KIND_CHUNK;
        it.offset = offset;
        return it;
    endfunction

    function automatic media_item_t sample_item(logic [23:0] size, logic sync, logic fin);
        media_item_t it;
        it = random_item();
        it.kind = mgp_pkg::KIND_SAMPLE;
        it.size = size;
        it.sync = sync;
        it.fin = fin;
        return it;
    endfunction

    function automatic media_item_t noise_item();
        media_item_t it;
        it = random_item();
        it.kind = 2'($urandom_range(1, 3));
        return it;
    endfunction

    task automatic send_item(input media_item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, it.sync, it.size, it.offset, it.per_chunk, it.first_chunk};
        s_axis_tuser <= it.kind;
        s_axis_tlast <= it.fin;
        do @(posedge clk); while (!s_axis_tready);
        if (it.kind != KIND_IGNORED)
            items_sent++;
    endtask

    task automatic wait_drained(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (gop_check.outstanding() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_config(input logic [31:0] total, input logic [15:0] count,
                                input logic [31:0] average);
        logic [31:0] vals [3];
        logic [1:0]  idx [3];
        vals = '{total, {16'd0, count}, average};
        idx = '{mgp_pkg::CFG_TOTAL_SIZE, mgp_pkg::CFG_PARTITION_COUNT,
                mgp_pkg::CFG_AVERAGE_SIZE};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            gop_check.set_register(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // empty table, then samples with no chunk behind them
        send_item(chunk_item(32'd0));
        send_item(sample_item(24'd100, 1'b1, 1'b0));
        send_item(sample_item(24'hFFFFFF, 1'b0, 1'b1));
        send_item(random_item() | {KIND_IGNORED, 106'd0});
        send_item(load_item(32'd1, 16'd2));
        send_item(load_item(32'd2, 16'd3));
        send_item(load_item(32'd4, 16'hFFFF));
        // samples ahead of the first sync, then a chunk run dry
        send_item(chunk_item(32'd1000));
        send_item(sample_item(24'd500, 1'b0, 1'b0));
        send_item(sample_item(24'd700, 1'b1, 1'b0));
        send_item(sample_item(24'd0, 1'b1, 1'b0));
        send_item(chunk_item(32'hFFFFFF9B));
        send_item(sample_item(24'd50, 1'b0, 1'b0));
        send_item(sample_item(24'd200, 1'b1, 1'b0));
        send_item(sample_item(24'hFFFFFF, 1'b1, 1'b0));
        send_item(chunk_item(32'd5000));
        send_item(chunk_item(32'd6000));
        send_item(sample_item(24'd3000, 1'b1, 1'b0));
        send_item(sample_item(24'd0, 1'b0, 1'b0));
        // sync on the closing sample joins the open gop
        send_item(sample_item(24'd4000, 1'b1, 1'b1));
        send_item(sample_item(24'd10, 1'b1, 1'b0));
        send_item(chunk_item(32'd0));
        send_item(sample_item(24'd10, 1'b1, 1'b1));
    endtask

    task automatic send_file();
        int          chunks;
        int          samples;
        logic [31:0] base;
        logic [23:0] size;
        logic        opened;
        chunks = $urandom_range(1, 6);
        base = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 4000);
        opened = 1'b0;
        for (int c = 0; c < chunks; c++)
        begin
            send_item(chunk_item(base));
            samples = $urandom_range((c == chunks - 1) ? 1 : 0, 4);
            for (int s = 0; s < samples; s++)
            begin
                size = ($urandom_range(15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1500));
                send_item(sample_item(size,
                                      opened ? ($urandom_range(4) == 0) : ($urandom_range(3) != 0),
                                      c == chunks - 1 && s == samples - 1));
                opened = 1'b1;
                base = base + {8'd0, size};
            end
        end
    endtask

    task automatic run_files(input int target);
        int goal;
        bit first_file;
        goal = items_sent + target;
        first_file = 1'b1;
        while (items_sent < goal)
        begin
            if (first_file || $urandom_range(24) == 0)
                wait_drained(0);
            first_file = 1'b0;
            if ($urandom_range(5) == 0)
                send_item(load_item($urandom_range(1, 8),
                                    ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4))));
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 3)) send_item(noise_item());
            send_file();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        src_idle = 31;
        dst_idle = 64;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(32'd20000, 16'd4, 32'd3000);
        run_directed();
        wait_drained(SETTLE_CYCLES);
        write_config(32'd50000, 16'd8, 32'd2500);
        run_files(80);
        wait_drained(SETTLE_CYCLES);
        write_config(32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
        run_files(80);
        wait_drained(SETTLE_CYCLES);

        src_idle = 64;
        dst_idle = 31;
        write_config(32'd1, 16'd1, 32'd1);
        run_files(80);
        wait_drained(SETTLE_CYCLES);
        write_config(32'd30000, 16'hFFFF, 32'd1);
        run_files(80);
        wait_drained(SETTLE_CYCLES);

        src_idle = 0;
        dst_idle = 0;
        write_config(32'd0, 16'd0, 32'd0);
        run_files(80);
        // overfill the entry table
        repeat (66) send_item(load_item($urandom, 16'($urandom)));
        send_item(load_item(32'hFFFFFFFF, 16'hFFFF));
        wait_drained(SETTLE_CYCLES);
        write_config($urandom, 16'($urandom_range(2, 10)), $urandom_range(500, 5000));
        run_files(90);
        wait_drained(SETTLE_CYCLES);

        if (gop_check.mismatches == 0 && gop_check.outstanding() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
